@@ hdl/unicode_escape_to_utf8_unit_macros.svh @@
// Assertion macros for the unicode escape to UTF-8 unit.
`ifndef UNICODE_ESCAPE_TO_UTF8_UNIT_MACROS_SVH
`define UNICODE_ESCAPE_TO_UTF8_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked at every rising edge out of reset.
`define UE2U_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define UE2U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define UE2U_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define UE2U_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/ue2u_pkg.sv @@
// Shared types and constants of the unicode escape to UTF-8 unit.
`default_nettype none
package ue2u_pkg;

    // What the back end must emit for one queued job.
    typedef enum logic {
        JOB_BYTE,   // pass code[7:0] through as one byte
        JOB_CODE    // encode code as UTF-8, one to three bytes
    } job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic [15:0] code;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0]  CH_BACKSLASH = 8'h5c;
    localparam logic [7:0]  CH_U         = 8'h75;
    localparam logic [7:0]  CH_SLASH     = 8'h2f;

    localparam logic [15:0] LIMIT_1B     = 16'h007f;
    localparam logic [15:0] LIMIT_2B     = 16'h07ff;
    localparam logic [7:0]  LEAD_2B      = 8'hc0;
    localparam logic [7:0]  LEAD_3B      = 8'he0;
    localparam logic [7:0]  CONT_MARK    = 8'h80;

endpackage
`default_nettype wire

@@ hdl/ue2u_in_if.sv @@
// Input channel: escaped text bytes with end-of-text mark.
`default_nettype none
interface ue2u_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink (input valid, input in_byte, input text_end, output ready);
endinterface
`default_nettype wire

@@ hdl/ue2u_out_if.sv @@
// Output channel: decoded UTF-8 bytes with last-of-run mark.
`default_nettype none
interface ue2u_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       run_last;

    modport source (output valid, output out_byte, output run_last, input ready);
    modport sink (input valid, input out_byte, input run_last, output ready);
endinterface
`default_nettype wire

@@ hdl/ue2u_front.sv @@
// Front end: escape parser that turns input bytes into output jobs.
`default_nettype none
module ue2u_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    ue2u_in_if.sink               escaped,
    input  wire ue2u_pkg::q_status_t q_stat,
    output logic                  push,
    output ue2u_pkg::job_t        push_job
);
    import ue2u_pkg::*;

    typedef enum logic [2:0] {
        PH_TEXT,
        PH_BACKSLASH,
        PH_HEX0,
        PH_HEX1,
        PH_HEX2,
        PH_HEX3
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [15:0] code_reg, code_next;
    logic        stopped_reg, stopped_next;

    logic        accept;
    logic [7:0]  c;
    logic [4:0]  hex;
    logic [15:0] code_step;
    logic        stopped_step;

    // Returns {is_hex, digit}.
    function automatic logic [4:0] hex_decode(input logic [7:0] b);
        logic [4:0] r;
        r = '0;
        if (b >= 8'h30 && b <= 8'h39)
        begin
            r = {1'b1, b[3:0]};
        end
        else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46))
        begin
            r = {1'b1, b[3:0] + 4'd9};
        end
        return r;
    endfunction

    assign escaped.ready = !q_stat.full;
    assign accept        = escaped.valid && escaped.ready;
    assign c             = escaped.in_byte;
    assign hex           = hex_decode(c);

    // A non-hex byte ends the digit run for the rest of the escape.
    always_comb
    begin
        if (!stopped_reg && hex[4])
        begin
            code_step    = {code_reg[11:0], hex[3:0]};
            stopped_step = stopped_reg;
        end
        else
        begin
            code_step    = code_reg;
            stopped_step = 1'b1;
        end
    end

    always_comb
    begin
        phase_next    = phase_reg;
        code_next     = code_reg;
        stopped_next  = stopped_reg;
        push          = 1'b0;
        push_job.kind = JOB_BYTE;
        push_job.code = {8'h00, c};
        unique case (phase_reg)
            PH_BACKSLASH:
            begin
                if (c == CH_U)
                begin
                    phase_next   = PH_HEX0;
                    code_next    = '0;
                    stopped_next = 1'b0;
                end
                else
                begin
                    push       = (c == CH_SLASH);
                    phase_next = PH_TEXT;
                end
            end
            PH_HEX0, PH_HEX1, PH_HEX2:
            begin
                code_next    = code_step;
                stopped_next = stopped_step;
                phase_next   = phase_t'(phase_reg + 3'd1);
            end
            PH_HEX3:
            begin
                // A zero code point emits nothing.
                push          = (code_step != '0);
                push_job.kind = JOB_CODE;
                push_job.code = code_step;
                phase_next    = PH_TEXT;
                code_next     = '0;
                stopped_next  = 1'b0;
            end
            default:
            begin
                if (c == CH_BACKSLASH)
                begin
                    phase_next = PH_BACKSLASH;
                end
                else
                begin
                    push = 1'b1;
                end
            end
        endcase
        // Drop any open escape at the end of the text.
        if (escaped.text_end)
        begin
            phase_next   = PH_TEXT;
            code_next    = '0;
            stopped_next = 1'b0;
        end
        if (!accept)
        begin
            push = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_TEXT;
            code_reg    <= '0;
            stopped_reg <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            code_reg    <= code_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/ue2u_queue.sv @@
// Job queue between front end and back end.
`default_nettype none
module ue2u_queue #(
    parameter int DEPTH = ue2u_pkg::QUEUE_DEPTH
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire ue2u_pkg::job_t      push_job,
    input  wire logic                pop,
    output ue2u_pkg::job_t           head,
    output ue2u_pkg::q_status_t      q_stat
);
    import ue2u_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    job_t          mem_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign do_push      = push && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign head         = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
            end
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/ue2u_back.sv @@
// Back end: emits the bytes of each queued job into the output register.
`default_nettype none
module ue2u_back (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ue2u_pkg::job_t      head,
    input  wire ue2u_pkg::q_status_t q_stat,
    output logic                     pop,
    ue2u_out_if.source               decoded
);
    import ue2u_pkg::*;

    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       run_last_reg, run_last_next;
    logic [1:0] step_reg, step_next;

    logic       slot_free;
    logic [1:0] nbytes;
    logic [7:0] cur_byte;

    assign slot_free        = !out_valid_reg || decoded.ready;
    assign decoded.valid    = out_valid_reg;
    assign decoded.out_byte = out_byte_reg;
    assign decoded.run_last = run_last_reg;

    always_comb
    begin
        if (head.kind == JOB_BYTE || head.code <= LIMIT_1B)
        begin
            nbytes = 2'd1;
        end
        else if (head.code <= LIMIT_2B)
        begin
            nbytes = 2'd2;
        end
        else
        begin
            nbytes = 2'd3;
        end
    end

    always_comb
    begin
        cur_byte = head.code[7:0];
        if (head.kind == JOB_CODE)
        begin
            case (nbytes)
                2'd2:
                begin
                    cur_byte = (step_reg == 2'd0) ? (LEAD_2B | {3'b000, head.code[10:6]})
                                                  : (CONT_MARK | {2'b00, head.code[5:0]});
                end
                2'd3:
                begin
                    case (step_reg)
                        2'd0:    cur_byte = LEAD_3B | {4'h0, head.code[15:12]};
                        2'd1:    cur_byte = CONT_MARK | {2'b00, head.code[11:6]};
                        default: cur_byte = CONT_MARK | {2'b00, head.code[5:0]};
                    endcase
                end
                default:
                begin
                    cur_byte = {1'b0, head.code[6:0]};
                end
            endcase
        end
    end

    // Load the next byte whenever the output register is free; pop on the last one.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        run_last_next  = run_last_reg;
        step_next      = step_reg;
        pop            = 1'b0;
        if (slot_free)
        begin
            out_valid_next = !q_stat.empty;
            if (!q_stat.empty)
            begin
                out_byte_next = cur_byte;
                run_last_next = (step_reg == nbytes - 2'd1);
                if (step_reg == nbytes - 2'd1)
                begin
                    pop       = 1'b1;
                    step_next = '0;
                end
                else
                begin
                    step_next = step_reg + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            step_reg      <= '0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        run_last_reg <= run_last_next;
    end

endmodule
`default_nettype wire

@@ hdl/unicode_escape_to_utf8_unit.sv @@
// Path: an accepted item is written into the job queue, then its first output byte is loaded into the output register.
// Throughput: one input item per cycle while the job queue has room; one output byte per
// cycle while the output is ready, so a three-byte code point holds the back end across its
// three bytes and a job queue of QUEUE_DEPTH entries absorbs the difference.
// Reset: asynchronous, active low; escape state returns to plain text, queue empties,
// output goes invalid.
`default_nettype none
`include "unicode_escape_to_utf8_unit_macros.svh"
module unicode_escape_to_utf8_unit #(
    parameter int QUEUE_DEPTH = ue2u_pkg::QUEUE_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ue2u_in_if.sink    escaped,
    ue2u_out_if.source decoded
);
    import ue2u_pkg::*;

    logic      q_push;
    job_t      push_job;
    logic      q_pop;
    job_t      q_head;
    q_status_t q_stat;

    ue2u_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .escaped  (escaped),
        .q_stat   (q_stat),
        .push     (q_push),
        .push_job (push_job)
    );

    ue2u_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (q_head),
        .q_stat   (q_stat)
    );

    ue2u_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (q_head),
        .q_stat  (q_stat),
        .pop     (q_pop),
        .decoded (decoded)
    );

    `UE2U_ASSERT_SAME(a_no_overflow, clk, rst_n, q_push, !q_stat.full, "job pushed into full queue")
    `UE2U_ASSERT_NEXT(a_push_lands, clk, rst_n, q_push, !q_stat.empty, "pushed job vanished")
    `UE2U_ASSERT_SAME(a_run_held, clk, rst_n, decoded.valid && !decoded.run_last, !q_stat.empty, "job popped before its last byte")

endmodule
`default_nettype wire
